// ===== sv/ris_pkg.sv =====
// ============================================================================
// ris_pkg
// Shared types, register indexes, mode codes and constants of the report
// interval scheduler.
// ============================================================================
`default_nettype none

package ris_pkg;

  localparam int CntW   = 16;
  localparam int ParamW = 8;
  localparam int SpeedW = 12;
  localparam int ModeW  = 2;
  localparam int CfgAddrW = 3;
  localparam int InDataW  = 24;
  localparam int OutDataW = 8;

  localparam int PRECONNECT_TICKS   = 5;
  localparam int PARAM_PERIOD       = 60;
  localparam int PARAM_SHORT_PERIOD = 20;
  localparam int SPEED_MOTION_TENTHS = 30;

  // Vehicle modes
  localparam logic [ModeW-1:0] MODE_MOTION = 2'd0;
  localparam logic [ModeW-1:0] MODE_HALT   = 2'd1;
  localparam logic [ModeW-1:0] MODE_SLEEP  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgAddrW-1:0] REG_MOTION_IV    = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_HALT_IV      = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_SLEEP_IV     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_FULL_IV      = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_HEALTH_IV    = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_EMERGENCY_IV = 3'd5;
  localparam logic [CfgAddrW-1:0] REG_HALT_DWELL   = 3'd6;
  localparam logic [CfgAddrW-1:0] REG_SLEEP_DWELL  = 3'd7;

  typedef struct packed {
    logic [CntW-1:0] motion_interval;
    logic [CntW-1:0] halt_interval;
    logic [CntW-1:0] sleep_interval;
    logic [CntW-1:0] full_interval;
    logic [CntW-1:0] health_interval;
    logic [CntW-1:0] emergency_interval;
    logic [CntW-1:0] halt_dwell;
    logic [CntW-1:0] sleep_dwell;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    motion_interval:    16'd10,
    halt_interval:      16'd60,
    sleep_interval:     16'd120,
    full_interval:      16'd300,
    health_interval:    16'd60,
    emergency_interval: 16'd5,
    halt_dwell:         16'd60,
    sleep_dwell:        16'd300
  };

  typedef struct packed {
    logic              ignition_on;
    logic [SpeedW-1:0] speed_tenths;
    logic              sos_active;
    logic              tamper_active;
    logic              tilt_active;
    logic              overspeed_active;
    logic              neighbours_known;
  } in_item_t;

  typedef struct packed {
    logic             normal_ready;
    logic             full_ready;
    logic             health_ready;
    logic             critical_ready;
    logic             param_ready;
    logic             connect_request;
    logic [ModeW-1:0] vehicle_mode;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/ris_engine.sv =====
// ============================================================================
// ris_engine
// Report counters, dwell counters and vehicle mode; advances one tick per
// enabled cycle and returns the result item of that tick.
// ============================================================================
`default_nettype none

module ris_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire ris_pkg::cfg_t     cfg,
  input  wire ris_pkg::in_item_t item,
  output ris_pkg::out_item_t     result
);
  import ris_pkg::*;

  logic [CntW-1:0]   normal_r, normal_nxt;
  logic [CntW-1:0]   full_r, full_nxt;
  logic [CntW-1:0]   health_r, health_nxt;
  logic [CntW-1:0]   crit_r, crit_nxt;
  logic [ParamW-1:0] param_r, param_nxt;
  logic [ModeW-1:0]  mode_r, mode_nxt;
  logic [CntW-1:0]   stop_r, stop_nxt;
  logic [CntW-1:0]   dwell_r, dwell_nxt;

  logic [CntW-1:0] cur_iv, crit_iv;
  logic            alarm, moving;
  logic [CntW:0]   n_inc, f_inc, h_inc, c_inc;
  logic            n_fire, f_fire, h_fire, c_fire, p_fire;
  logic            near_crit, near_other;
  logic [ParamW-1:0] pthr;

  always_comb begin
    unique case (mode_r)
      MODE_MOTION: cur_iv = cfg.motion_interval;
      MODE_SLEEP:  cur_iv = cfg.sleep_interval;
      default:     cur_iv = cfg.halt_interval;
    endcase
  end

  assign alarm   = item.sos_active | item.tamper_active | item.tilt_active
                 | item.overspeed_active;
  assign crit_iv = (item.sos_active | item.tamper_active) ? cfg.emergency_interval
                                                          : cur_iv;

  // Counts are compared one bit wider so that count + 1 never wraps.
  assign n_inc = {1'b0, normal_r} + (CntW+1)'(1);
  assign f_inc = {1'b0, full_r}   + (CntW+1)'(1);
  assign h_inc = {1'b0, health_r} + (CntW+1)'(1);
  assign c_inc = {1'b0, crit_r}   + (CntW+1)'(1);

  assign n_fire = n_inc >= {1'b0, cur_iv};
  assign f_fire = f_inc >= {1'b0, cfg.full_interval};
  assign h_fire = h_inc >= {1'b0, cfg.health_interval};
  assign c_fire = c_inc >= {1'b0, crit_iv};

  assign near_crit  = ({1'b0, crit_r} + (CntW+1)'(PRECONNECT_TICKS)) >= {1'b0, crit_iv};
  assign near_other =
      (({1'b0, normal_r} + (CntW+1)'(PRECONNECT_TICKS)) >= {1'b0, cur_iv})
    | (({1'b0, full_r}   + (CntW+1)'(PRECONNECT_TICKS)) >= {1'b0, cfg.full_interval})
    | (({1'b0, health_r} + (CntW+1)'(PRECONNECT_TICKS)) >= {1'b0, cfg.health_interval});

  assign normal_nxt = n_fire ? '0 : n_inc[CntW-1:0];
  assign full_nxt   = f_fire ? '0 : f_inc[CntW-1:0];
  assign health_nxt = h_fire ? '0 : h_inc[CntW-1:0];
  assign crit_nxt   = (!alarm || c_fire) ? '0 : c_inc[CntW-1:0];

  assign pthr      = item.neighbours_known ? ParamW'(PARAM_PERIOD)
                                           : ParamW'(PARAM_SHORT_PERIOD);
  assign p_fire    = param_r >= pthr;
  assign param_nxt = p_fire ? '0 : param_r + ParamW'(1);

  assign moving = item.ignition_on && (item.speed_tenths > SpeedW'(SPEED_MOTION_TENTHS));

  // Mode update. A halt entered on this tick counts its first dwell tick at once.
  always_comb begin
    logic [ModeW-1:0] mid_mode;
    logic [CntW-1:0]  stop_inc;
    logic [CntW-1:0]  dwell_base;
    logic [CntW-1:0]  dwell_inc;
    mode_nxt   = mode_r;
    stop_nxt   = stop_r;
    dwell_nxt  = dwell_r;
    mid_mode   = mode_r;
    stop_inc   = stop_r + CntW'(1);
    dwell_base = dwell_r;
    dwell_inc  = '0;
    if (moving) begin
      if (mode_r == MODE_HALT || mode_r == MODE_SLEEP) begin
        mode_nxt = MODE_MOTION;
        stop_nxt = '0;
      end
    end else begin
      if (mode_r == MODE_MOTION) begin
        if (stop_inc >= cfg.halt_dwell) begin
          mid_mode   = MODE_HALT;
          dwell_base = '0;
          stop_nxt   = '0;
        end else begin
          stop_nxt = stop_inc;
        end
      end
      mode_nxt  = mid_mode;
      dwell_nxt = dwell_base;
      if (mid_mode == MODE_HALT) begin
        dwell_inc = dwell_base + CntW'(1);
        if (dwell_inc >= cfg.sleep_dwell) begin
          mode_nxt  = MODE_SLEEP;
          dwell_nxt = '0;
        end else begin
          dwell_nxt = dwell_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r <= '0;
      full_r   <= '0;
      health_r <= '0;
      crit_r   <= '0;
      param_r  <= '0;
      mode_r   <= MODE_HALT;
      stop_r   <= '0;
      dwell_r  <= '0;
    end else if (en) begin
      normal_r <= normal_nxt;
      full_r   <= full_nxt;
      health_r <= health_nxt;
      crit_r   <= crit_nxt;
      param_r  <= param_nxt;
      mode_r   <= mode_nxt;
      stop_r   <= stop_nxt;
      dwell_r  <= dwell_nxt;
    end
  end

  assign result.normal_ready    = n_fire;
  assign result.full_ready      = f_fire;
  assign result.health_ready    = h_fire;
  assign result.critical_ready  = alarm && c_fire;
  assign result.param_ready     = p_fire;
  assign result.connect_request = (alarm && near_crit) || near_other;
  assign result.vehicle_mode    = mode_nxt;

endmodule

`default_nettype wire

// ===== sv/report_interval_scheduler.sv =====
// Path: an accepted item passes through the input register, then the result
//   register, before it is presented at out_tvalid.
// Throughput: one item per cycle while out_tready is high; the tick state
//   updates as an item enters the result register; back-to-back items chain.
// Reset (rst_n low, synchronous): both registers empty, counters zero, mode halt,
//   configuration registers at their defaults.
// ============================================================================
// report_interval_scheduler
// Per-tick report timing for a vehicle tracker: five report counters, a
// motion/halt/sleep mode and a connect request ahead of due reports.
// ============================================================================
`default_nettype none

module report_interval_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [ris_pkg::CfgAddrW-1:0]  cfg_addr,
  input  wire logic [ris_pkg::CntW-1:0]      cfg_wdata,
  // Input items, one per tick
  input  wire logic                          in_tvalid,
  output      logic                          in_tready,
  // in_tdata, from bit 0: ignition_on, speed_tenths[11:0], sos_active,
  // tamper_active, tilt_active, overspeed_active, neighbours_known, zero pad
  input  wire logic [ris_pkg::InDataW-1:0]   in_tdata,
  // Result items
  output      logic                          out_tvalid,
  input  wire logic                          out_tready,
  // out_tdata, from bit 0: normal_ready, full_ready, health_ready,
  // critical_ready, param_ready, connect_request, vehicle_mode[1:0]
  output      logic [ris_pkg::OutDataW-1:0]  out_tdata
);
  import ris_pkg::*;

  // Configuration registers. The user must ensure they are only written while the block is idle; not enforced.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MOTION_IV:    cfg_r.motion_interval    <= cfg_wdata;
        REG_HALT_IV:      cfg_r.halt_interval      <= cfg_wdata;
        REG_SLEEP_IV:     cfg_r.sleep_interval     <= cfg_wdata;
        REG_FULL_IV:      cfg_r.full_interval      <= cfg_wdata;
        REG_HEALTH_IV:    cfg_r.health_interval    <= cfg_wdata;
        REG_EMERGENCY_IV: cfg_r.emergency_interval <= cfg_wdata;
        REG_HALT_DWELL:   cfg_r.halt_dwell         <= cfg_wdata;
        REG_SLEEP_DWELL:  cfg_r.sleep_dwell        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register. It holds the next tick until the result register has room.
  logic      in_v_r;
  in_item_t  in_d_r;
  in_item_t  in_unpacked;
  logic      out_v_r;
  out_item_t out_d_r;
  out_item_t result;
  logic      out_free;
  logic      advance;

  assign out_free  = !out_v_r || out_tready;
  assign advance   = in_v_r && out_free;
  assign in_tready = !in_v_r || out_free;

  assign in_unpacked.ignition_on      = in_tdata[0];
  assign in_unpacked.speed_tenths     = in_tdata[12:1];
  assign in_unpacked.sos_active       = in_tdata[13];
  assign in_unpacked.tamper_active    = in_tdata[14];
  assign in_unpacked.tilt_active      = in_tdata[15];
  assign in_unpacked.overspeed_active = in_tdata[16];
  assign in_unpacked.neighbours_known = in_tdata[17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_d_r <= in_unpacked;
    end
  end

  // The engine commits one tick of state exactly when its result is loaded.
  ris_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .cfg    (cfg_r),
    .item   (in_d_r),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_d_r <= result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_d_r.vehicle_mode, out_d_r.connect_request,
                       out_d_r.param_ready, out_d_r.critical_ready,
                       out_d_r.health_ready, out_d_r.full_ready,
                       out_d_r.normal_ready};

endmodule

`default_nettype wire

// ===== sv/ris_checker.sv =====
// ============================================================================
// ris_checker
// Port-level checks of the report interval scheduler, bound to its top level.
// ============================================================================
`default_nettype none

module ris_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [ris_pkg::OutDataW-1:0]  out_tdata
);
  import ris_pkg::*;

  // A result that is not taken stays offered unchanged.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result item changed or dropped");

  // Reset empties the pipeline.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // With nothing waiting at the output the input side must not stall.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_tvalid |-> in_tready)
    else $error("input stalled while output side is empty");

  // The reported mode is always motion, halt or sleep.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:6] == MODE_MOTION || out_tdata[7:6] == MODE_HALT
                    || out_tdata[7:6] == MODE_SLEEP))
    else $error("invalid vehicle mode reported");

endmodule

bind report_interval_scheduler ris_checker u_ris_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== dv/report_interval_scheduler_test.sv =====
// ============================================================================
// report_interval_scheduler_test
// Self-checking testbench for the report interval scheduler. A short table of
// directed ticks is followed by phases of random ticks under several register
// settings. Every result item is checked against typed values or a cycle-free
// model of the report counters and the motion/halt/sleep mode in this module.
// ============================================================================
`default_nettype none

module report_interval_scheduler_test;
  import ris_pkg::*;

  // One row of the directed table: the packed tick and, where it is obvious
  // from the reset state, the result typed in by hand.
  typedef struct packed {
    logic [InDataW-1:0]  tdata;
    logic                typed;
    logic [OutDataW-1:0] want;
  } row_t;

  localparam int PlanRows = 24;
  // Number of cycles the receiver refuses results during a forced hold-off.
  localparam int HoldCycles = 60;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgAddrW-1:0] cfg_addr;
  logic [CntW-1:0]     cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  // in_tdata, from bit 0: ignition_on, speed_tenths[11:0], sos_active,
  // tamper_active, tilt_active, overspeed_active, neighbours_known, zero pad
  logic [InDataW-1:0]  in_tdata;
  logic                out_tvalid;
  logic                out_tready;
  // out_tdata, from bit 0: normal_ready, full_ready, health_ready,
  // critical_ready, param_ready, connect_request, vehicle_mode[1:0]
  logic [OutDataW-1:0] out_tdata;

  report_interval_scheduler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Model of the scheduler. It holds its own copy of the registers and of the
  // tick state, and is advanced once per accepted item.
  // --------------------------------------------------------------------------
  logic [CntW-1:0]   cfg_copy [8];
  logic [CntW-1:0]   norm_cnt, full_cnt, hlth_cnt, crit_cnt, stop_cnt, dwell_cnt;
  logic [ParamW-1:0] parm_cnt;
  logic [ModeW-1:0]  mode_now;

  // Results still owed by the block, oldest first.
  logic [OutDataW-1:0] pending_reports [$];

  int mismatch_count = 0;
  int reports_seen   = 0;
  int idle_pct       = 0;
  int hold_asked     = 0;
  int hold_served    = 0;

  // Random tick shaping: runs of moving or stopped ticks, and alarm bursts.
  int         run_left   = 0;
  logic       run_moving = 1'b0;
  int         alarm_left = 0;
  logic [3:0] alarm_set  = '0;
  logic       ngh_now    = 1'b0;

  row_t plan [PlanRows];

  // A report is close when fewer than PRECONNECT_TICKS ticks remain. The
  // compare is done in int so that a count near 65535 does not wrap.
  function automatic logic soon(input logic [CntW-1:0] c, input logic [CntW-1:0] p);
    return int'(c) + PRECONNECT_TICKS >= int'(p);
  endfunction

  task automatic bump(inout logic [CntW-1:0] c, input logic [CntW-1:0] p,
                      output logic fired);
    if (int'(c) + 1 >= int'(p)) begin
      c = '0;
      fired = 1'b1;
    end else begin
      c = c + 1'b1;
      fired = 1'b0;
    end
  endtask

  function automatic logic [InDataW-1:0] pack_tick(
    input logic ign, input logic [SpeedW-1:0] spd, input logic sos, input logic tmp,
    input logic tilt, input logic ovr, input logic ngh);
    return {6'b0, ngh, ovr, tilt, tmp, sos, spd, ign};
  endfunction

  function automatic row_t row(
    input logic ign, input logic [SpeedW-1:0] spd, input logic sos, input logic tmp,
    input logic tilt, input logic ovr, input logic ngh, input logic typed,
    input logic [OutDataW-1:0] want);
    row_t r;
    r.tdata = pack_tick(ign, spd, sos, tmp, tilt, ovr, ngh);
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  task automatic clear_schedule();
    cfg_copy[REG_MOTION_IV]    = CFG_RESET.motion_interval;
    cfg_copy[REG_HALT_IV]      = CFG_RESET.halt_interval;
    cfg_copy[REG_SLEEP_IV]     = CFG_RESET.sleep_interval;
    cfg_copy[REG_FULL_IV]      = CFG_RESET.full_interval;
    cfg_copy[REG_HEALTH_IV]    = CFG_RESET.health_interval;
    cfg_copy[REG_EMERGENCY_IV] = CFG_RESET.emergency_interval;
    cfg_copy[REG_HALT_DWELL]   = CFG_RESET.halt_dwell;
    cfg_copy[REG_SLEEP_DWELL]  = CFG_RESET.sleep_dwell;
    norm_cnt  = '0;
    full_cnt  = '0;
    hlth_cnt  = '0;
    crit_cnt  = '0;
    parm_cnt  = '0;
    stop_cnt  = '0;
    dwell_cnt = '0;
    mode_now  = MODE_HALT;
  endtask

  // Advance the model by one tick and return the result item it predicts.
  task automatic schedule_tick(input logic [InDataW-1:0] d,
                               output logic [OutDataW-1:0] res);
    logic             ign, sos, tmp, tilt, ovr, ngh, alarm, moving;
    logic             conn, n_r, f_r, h_r, c_r, p_r;
    logic [SpeedW-1:0] spd;
    logic [CntW-1:0]  cur, crit_iv;
    logic [ParamW-1:0] pthr;
    ign  = d[0];
    spd  = d[12:1];
    sos  = d[13];
    tmp  = d[14];
    tilt = d[15];
    ovr  = d[16];
    ngh  = d[17];
    alarm = sos | tmp | tilt | ovr;

    // The normal period follows the mode as it stood before this tick.
    case (mode_now)
      MODE_MOTION: cur = cfg_copy[REG_MOTION_IV];
      MODE_SLEEP:  cur = cfg_copy[REG_SLEEP_IV];
      default:     cur = cfg_copy[REG_HALT_IV];
    endcase
    // SOS and tamper shorten the critical period; tilt and overspeed alone
    // report at the normal rate.
    crit_iv = (sos | tmp) ? cfg_copy[REG_EMERGENCY_IV] : cur;

    // The connect request looks at the counts before they move.
    if (alarm && soon(crit_cnt, crit_iv))
      conn = 1'b1;
    else
      conn = soon(norm_cnt, cur) || soon(full_cnt, cfg_copy[REG_FULL_IV]) ||
             soon(hlth_cnt, cfg_copy[REG_HEALTH_IV]);

    bump(norm_cnt, cur, n_r);
    bump(full_cnt, cfg_copy[REG_FULL_IV], f_r);
    bump(hlth_cnt, cfg_copy[REG_HEALTH_IV], h_r);
    c_r = 1'b0;
    if (alarm)
      bump(crit_cnt, crit_iv, c_r);
    else
      crit_cnt = '0;

    pthr = ngh ? ParamW'(PARAM_PERIOD) : ParamW'(PARAM_SHORT_PERIOD);
    if (parm_cnt >= pthr) begin
      p_r = 1'b1;
      parm_cnt = '0;
    end else begin
      p_r = 1'b0;
      parm_cnt = parm_cnt + 1'b1;
    end

    // Mode update. A halt entered on this tick already counts its first
    // dwell tick, so a zero sleep dwell can take motion to sleep at once.
    moving = ign && (spd > SPEED_MOTION_TENTHS);
    if (moving) begin
      if (mode_now == MODE_HALT || mode_now == MODE_SLEEP) begin
        mode_now = MODE_MOTION;
        stop_cnt = '0;
      end
    end else begin
      if (mode_now == MODE_MOTION) begin
        stop_cnt = stop_cnt + 1'b1;
        if (stop_cnt >= cfg_copy[REG_HALT_DWELL]) begin
          mode_now  = MODE_HALT;
          dwell_cnt = '0;
          stop_cnt  = '0;
        end
      end
      if (mode_now == MODE_HALT) begin
        dwell_cnt = dwell_cnt + 1'b1;
        if (dwell_cnt >= cfg_copy[REG_SLEEP_DWELL]) begin
          mode_now  = MODE_SLEEP;
          dwell_cnt = '0;
        end
      end
    end

    res = {mode_now, conn, p_r, c_r, h_r, f_r, n_r};
  endtask

  // --------------------------------------------------------------------------
  // Driving. Inputs change on the falling edge; handshakes are sampled on the
  // rising edge, before the block's own registers update.
  // --------------------------------------------------------------------------

  // Offer one tick, wait for it to be taken, record what it should produce,
  // and then maybe leave the input idle for a short burst.
  task automatic offer(input logic [InDataW-1:0] d, input logic typed,
                       input logic [OutDataW-1:0] want);
    logic [OutDataW-1:0] predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    schedule_tick(d, predicted);
    pending_reports.push_back(typed ? want : predicted);
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
  endtask

  // Random tick. Most ticks belong to runs of driving or standing, so that
  // the dwell counters get far enough to change the mode; one in ten is
  // plain noise over all input bits.
  task automatic next_tick(output logic [InDataW-1:0] d);
    logic              ign;
    logic [SpeedW-1:0] spd;
    if ($urandom_range(0, 9) == 0) begin
      d = {6'b0, 18'($urandom)};
    end else begin
      if (run_left == 0) begin
        run_moving = 1'($urandom_range(0, 1));
        run_left   = $urandom_range(1, 40);
      end
      run_left--;
      if (alarm_left == 0) begin
        alarm_set  = ($urandom_range(0, 2) == 0) ? 4'b0 : 4'($urandom);
        alarm_left = $urandom_range(1, 25);
      end
      alarm_left--;
      if ($urandom_range(0, 19) == 0) ngh_now = ~ngh_now;

      if (run_moving) begin
        ign = 1'b1;
        spd = ($urandom_range(0, 7) == 0) ? 12'd31 : 12'($urandom_range(31, 4095));
      end else if ($urandom_range(0, 1) == 0) begin
        // Ignition off: speed does not matter.
        ign = 1'b0;
        spd = 12'($urandom);
      end else begin
        // Ignition on but creeping at or below the 3.0 km/h threshold.
        ign = 1'b1;
        spd = ($urandom_range(0, 3) == 0) ? 12'd30 : 12'($urandom_range(0, 30));
      end
      d = pack_tick(ign, spd, alarm_set[0], alarm_set[1], alarm_set[2], alarm_set[3],
                    ngh_now);
    end
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] a, input logic [CntW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    cfg_copy[a] = v;
    @(negedge clk);
  endtask

  // Rewrite all eight registers once the block has drained. Every tick
  // produces a result, so an empty queue means nothing is left in flight.
  task automatic load_settings(
    input logic [CntW-1:0] motion_iv, input logic [CntW-1:0] halt_iv,
    input logic [CntW-1:0] sleep_iv, input logic [CntW-1:0] full_iv,
    input logic [CntW-1:0] health_iv, input logic [CntW-1:0] emerg_iv,
    input logic [CntW-1:0] halt_dw, input logic [CntW-1:0] sleep_dw);
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(REG_MOTION_IV, motion_iv);
    write_reg(REG_HALT_IV, halt_iv);
    write_reg(REG_SLEEP_IV, sleep_iv);
    write_reg(REG_FULL_IV, full_iv);
    write_reg(REG_HEALTH_IV, health_iv);
    write_reg(REG_EMERGENCY_IV, emerg_iv);
    write_reg(REG_HALT_DWELL, halt_dw);
    write_reg(REG_SLEEP_DWELL, sleep_dw);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Either end of a register's range, or a short random period.
  function automatic logic [CntW-1:0] corner_val(input int lo);
    case ($urandom_range(0, 2))
      0:       return CntW'(lo);
      1:       return '1;
      default: return CntW'($urandom_range(lo, 8));
    endcase
  endfunction

  task automatic run_phase(input int n, input int idle, input logic hold);
    logic [InDataW-1:0] d;
    idle_pct = idle;
    if (hold) hold_asked++;
    repeat (n) begin
      next_tick(d);
      offer(d, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver. It stalls in short random bursts while idling is enabled, and
  // on request holds off for a long stretch so that the block backs up and
  // refuses input while the sender keeps offering.
  // --------------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_served != hold_asked) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_served++;
      end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Checker. Each accepted result is compared with the oldest prediction.
  // --------------------------------------------------------------------------
  logic [OutDataW-1:0] want_now;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("report %0d: unexpected result %02h", reports_seen, out_tdata);
      end else begin
        want_now = pending_reports.pop_front();
        if (out_tdata !== want_now) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"report %0d: want n%b f%b h%b c%b p%b conn%b mode%0d, ",
                      "got n%b f%b h%b c%b p%b conn%b mode%0d"}, reports_seen,
                     want_now[0], want_now[1], want_now[2], want_now[3],
                     want_now[4], want_now[5], want_now[7:6],
                     out_tdata[0], out_tdata[1], out_tdata[2], out_tdata[3],
                     out_tdata[4], out_tdata[5], out_tdata[7:6]);
        end
      end
      reports_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int i;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    clear_schedule();

    // Directed ticks under the reset settings. The first four results follow
    // directly from the reset state: a quiet first tick in halt, a tick just
    // above the motion threshold, then SOS and tamper where the emergency
    // period of five is already within the preconnect window.
    plan[0]  = row(1'b0, 12'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h40);
    plan[1]  = row(1'b1, 12'd31,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    plan[2]  = row(1'b1, 12'd30,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'h20);
    plan[3]  = row(1'b0, 12'd4095, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h20);
    // Tilt and overspeed alone use the normal period for the critical count.
    plan[4]  = row(1'b0, 12'd0,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    plan[5]  = row(1'b1, 12'd4095, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    plan[6]  = row(1'b1, 12'd4095, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00);
    // No alarm clears the critical count.
    plan[7]  = row(1'b1, 12'd2048, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    plan[8]  = row(1'b1, 12'h555,  1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00);
    plan[9]  = row(1'b0, 12'hAAA,  1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    // A stretch of driving under SOS: critical fires every five ticks, normal
    // every ten, and the short parameter period runs out.
    for (i = 10; i < 22; i++)
      plan[i] = row(1'b1, 12'(500 + i), 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    plan[22] = row(1'b1, 12'd0,    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    plan[23] = row(1'b0, 12'd1,    1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_pct = 10;
    for (i = 0; i < PlanRows; i++)
      offer(plan[i].tdata, plan[i].typed, plan[i].want);
    in_tvalid <= 1'b0;
    @(negedge clk);

    // Short periods and dwells, so that every counter fires often and the
    // mode cycles through motion, halt and sleep.
    load_settings(CntW'($urandom_range(1, 12)), CntW'($urandom_range(1, 12)),
                  CntW'($urandom_range(1, 12)), CntW'($urandom_range(1, 12)),
                  CntW'($urandom_range(1, 12)), CntW'($urandom_range(1, 12)),
                  CntW'($urandom_range(0, 10)), CntW'($urandom_range(0, 10)));
    run_phase(75, 20, 1'b0);

    // Lowest settings: every register period is one tick and both dwells are zero,
    // so a single standing tick takes motion straight to sleep. The receiver
    // also holds off for a long stretch here.
    load_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0);
    run_phase(75, 40, 1'b1);

    // Highest settings: no report whose period is a register falls due within the run.
    load_settings('1, '1, '1, '1, '1, '1, '1, '1);
    run_phase(60, 15, 1'b0);

    // A mix of extremes and short periods, with a second hold-off.
    load_settings(corner_val(1), corner_val(1), corner_val(1), corner_val(1),
                  corner_val(1), corner_val(1), corner_val(0), corner_val(0));
    run_phase(75, 30, 1'b1);

    load_settings(CntW'($urandom_range(1, 20)), CntW'($urandom_range(1, 20)),
                  CntW'($urandom_range(1, 20)), CntW'($urandom_range(5, 9)),
                  CntW'($urandom_range(5, 9)), CntW'($urandom_range(1, 8)),
                  CntW'($urandom_range(0, 25)), CntW'($urandom_range(0, 25)));
    run_phase(90, 25, 1'b0);

    // Last part: both sides run without idling.
    load_settings(CntW'($urandom_range(1, 12)), CntW'($urandom_range(1, 12)),
                  CntW'($urandom_range(1, 12)), CntW'($urandom_range(1, 30)),
                  CntW'($urandom_range(1, 30)), CntW'($urandom_range(1, 6)),
                  CntW'($urandom_range(0, 15)), CntW'($urandom_range(0, 15)));
    run_phase(80, 0, 1'b0);

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
